### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/ajfw_pkg.sv
package ajfw_pkg;

   localparam int DEPTH_FRAMES = 8192;
   localparam int PTR_W        = $clog2(DEPTH_FRAMES);
   localparam int CNT_W        = $clog2(DEPTH_FRAMES + 1);
   localparam int FRAMES_W     = 14;
   localparam int LEVEL_W      = 14;
   localparam int SAMPLE_W     = 16;
   localparam int WORD_W       = 2 * SAMPLE_W;
   localparam int SUM_W        = ((CNT_W > FRAMES_W) ? CNT_W : FRAMES_W) + 1;

   localparam logic [LEVEL_W-1:0] PREFETCH_RESET = LEVEL_W'(5120);

   // Request codes; the fourth code is a no-op.
   localparam logic [1:0] REQ_HEADER = 2'd0;
   localparam logic [1:0] REQ_FRAME  = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_NOP    = 2'd3;

   typedef enum logic [1:0] {
      MODE_PROCESSING  = 2'd0,
      MODE_PREFETCHING = 2'd1,
      MODE_DROPPING    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RESP
   } ctl_state_type;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [FRAMES_W-1:0] packet_frames;
      logic [SAMPLE_W-1:0] left_in;
      logic [SAMPLE_W-1:0] right_in;
   } req_item_type;

   typedef struct packed {
      logic                ok;
      logic [SAMPLE_W-1:0] left_out;
      logic [SAMPLE_W-1:0] right_out;
      logic [1:0]          buffer_mode;
      logic [13:0]         occupancy;
   } rsp_item_type;

   typedef struct packed {
      logic exec;
      logic load_samples;
   } ajfw_cmd_type;

   typedef struct packed {
      logic read_hit;
   } ajfw_stat_type;

endpackage

### rtl/ajfw_ram.sv
module ajfw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ajfw_ctrl.sv
module ajfw_ctrl
   import ajfw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  ajfw_stat_type stat,
   output ajfw_cmd_type  cmd
);

`include "assert_macros.svh"

   ctl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.read_hit ? ST_FETCH : ST_RESP;
            end
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall        = 1'b1;
      rsp_valid        = 1'b0;
      cmd.exec         = 1'b0;
      cmd.load_samples = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // No item is taken while reset is held.
            req_stall = reset;
            cmd.exec  = req_valid && !reset;
         end
         ST_FETCH: begin
            cmd.load_samples = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sample capture only ever follows a read that found a stored frame.
   `ASSERT_IMPL(a_fetch_after_hit, state_ff == ST_FETCH, $past(cmd.exec && stat.read_hit))
   // One item is in flight at a time.
   `ASSERT_NEXT(a_single_item, cmd.exec, !cmd.exec)

endmodule

### rtl/ajfw_datapath.sv
module ajfw_datapath
   import ajfw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  req_item_type        req_item,
   output rsp_item_type        rsp_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LEVEL_W-1:0]  csr_data,
   input  ajfw_cmd_type        cmd,
   output ajfw_stat_type       stat
);

`include "assert_macros.svh"

   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   stored_ff, stored_in;
   logic [CNT_W-1:0]   reserved_ff, reserved_in;
   logic               kept_ff, kept_in;
   mode_type           mode_ff, mode_in;
   logic [LEVEL_W-1:0] level_ff;

   logic                ok_ff, ok_in;
   logic [SAMPLE_W-1:0] left_ff, right_ff;
   logic [1:0]          mode_out_ff;
   logic [13:0]         occ_ff;

   logic               ram_we;
   logic               read_hit;
   logic [WORD_W-1:0]  ram_rdata;
   logic [SUM_W-1:0]   stored_ext, level_ext, fit_sum;
   logic [CNT_W-1:0]   occ_in;

   assign stored_ext = SUM_W'(stored_ff);
   assign level_ext  = SUM_W'(level_ff);
   assign fit_sum    = stored_ext + SUM_W'(req_item.packet_frames);

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      stored_in   = stored_ff;
      reserved_in = reserved_ff;
      kept_in     = kept_ff;
      mode_in     = mode_ff;
      ok_in       = 1'b0;
      ram_we      = 1'b0;
      read_hit    = 1'b0;
      case (req_item.req_type)
         REQ_HEADER: begin
            // An unfinished packet gives up its reservation first.
            reserved_in = '0;
            kept_in     = 1'b0;
            if (mode_ff == MODE_DROPPING) begin
               if (stored_ext <= level_ext) begin
                  mode_in = MODE_PROCESSING;
               end
            end else if (fit_sum <= SUM_W'(DEPTH_FRAMES)) begin
               ok_in       = 1'b1;
               reserved_in = CNT_W'(req_item.packet_frames);
               kept_in     = (req_item.packet_frames != '0);
               if (mode_ff == MODE_PREFETCHING && fit_sum >= level_ext) begin
                  mode_in = MODE_PROCESSING;
               end
            end else begin
               mode_in = MODE_DROPPING;
            end
         end
         REQ_FRAME: begin
            if (kept_ff && reserved_ff != '0) begin
               ram_we      = 1'b1;
               wr_ptr_in   = (wr_ptr_ff == PTR_W'(DEPTH_FRAMES - 1)) ? '0 : wr_ptr_ff + 1'b1;
               stored_in   = stored_ff + 1'b1;
               reserved_in = reserved_ff - 1'b1;
               kept_in     = (reserved_ff != CNT_W'(1));
               ok_in       = 1'b1;
            end
         end
         REQ_READ: begin
            if (mode_ff != MODE_PREFETCHING) begin
               if (stored_ff == '0) begin
                  mode_in = MODE_PREFETCHING;
               end else begin
                  read_hit  = 1'b1;
                  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH_FRAMES - 1)) ? '0 : rd_ptr_ff + 1'b1;
                  stored_in = stored_ff - 1'b1;
                  ok_in     = 1'b1;
               end
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign occ_in        = stored_in + reserved_in;
   assign stat.read_hit = read_hit;
   assign csr_ready     = !reset;

   ajfw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH_FRAMES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.exec && ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data ({req_item.right_in, req_item.left_in}),
      .rd_en   (cmd.exec && read_hit),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         stored_ff   <= '0;
         reserved_ff <= '0;
         kept_ff     <= 1'b0;
         mode_ff     <= MODE_PREFETCHING;
         level_ff    <= PREFETCH_RESET;
      end else begin
         if (cmd.exec) begin
            wr_ptr_ff   <= wr_ptr_in;
            rd_ptr_ff   <= rd_ptr_in;
            stored_ff   <= stored_in;
            reserved_ff <= reserved_in;
            kept_ff     <= kept_in;
            mode_ff     <= mode_in;
         end
         if (csr_valid && csr_ready) begin
            level_ff <= csr_data;
         end
      end
   end

   // Result register: status is known at accept, samples of a read hit follow in the next cycle.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff       <= ok_in;
         left_ff     <= '0;
         right_ff    <= '0;
         mode_out_ff <= mode_in;
         occ_ff      <= 14'(occ_in);
      end else if (cmd.load_samples) begin
         left_ff  <= ram_rdata[SAMPLE_W-1:0];
         right_ff <= ram_rdata[WORD_W-1:SAMPLE_W];
      end
   end

   assign rsp_item.ok          = ok_ff;
   assign rsp_item.left_out    = left_ff;
   assign rsp_item.right_out   = right_ff;
   assign rsp_item.buffer_mode = mode_out_ff;
   assign rsp_item.occupancy   = occ_ff;

   `ASSERT_IMPL(a_occ_bound, 1'b1,
                (SUM_W'(stored_ff) + SUM_W'(reserved_ff)) <= SUM_W'(DEPTH_FRAMES))
   `ASSERT_IMPL(a_kept_matches, 1'b1, kept_ff == (reserved_ff != '0))

endmodule

### rtl/audio_jitter_fifo_watermark_top.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    req_item  (req_item_type)
// rsp_      out        rsp_valid/stall    rsp_item  (rsp_item_type)
// csr_      in         csr_valid/ready    csr_data  (prefetch level)
//
// Headers, frames, no-op codes and reads that pop nothing are accepted, then their result is shown.
// A read that pops a frame also passes a fetch state, as the frame store has a registered read port.
// The next item is accepted in the cycle after the result is taken; rsp_stall holds the result back.
// Reset is synchronous and needs no clearing pass; frame store contents are unknown until written.
module audio_jitter_fifo_watermark_top
   import ajfw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LEVEL_W-1:0] csr_data
);

   ajfw_cmd_type  cmd;
   ajfw_stat_type stat;

   ajfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ajfw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

### tb/sv/tb_audio_jitter_fifo_watermark_top.sv
`timescale 1ns / 1ps

module tb_audio_jitter_fifo_watermark_top;
   import ajfw_pkg::*;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_item_type       req_item  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_item_type       rsp_item;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LEVEL_W-1:0] csr_data  = '0;

   audio_jitter_fifo_watermark_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Shadow of the jitter buffer, advanced once per accepted item.
   logic [WORD_W-1:0] shadow_frames [DEPTH_FRAMES];
   int                wr_ptr       = 0;
   int                rd_ptr       = 0;
   int                stored_cnt   = 0;
   int                reserved_cnt = 0;
   bit                packet_open  = 1'b0;
   mode_type          buf_mode     = MODE_PREFETCHING;
   int                level        = int'(PREFETCH_RESET);

   req_item_type req_backlog [$];
   rsp_item_type fifo_outcomes [$];
   req_item_type taken;
   rsp_item_type want;

   int errors       = 0;
   int rsp_taken    = 0;
   int send_wait    = 0;
   int rcv_wait     = 0;
   bit send_idling  = 1'b1;
   bit rcv_idling   = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int next_wait(input bit idling);
      return idling ? $urandom_range(0, 14) : 0;
   endfunction

   task automatic jitter_fifo_step(input req_item_type it);
      rsp_item_type r;
      int           frames;
      logic [WORD_W-1:0] w;
      r = '0;
      frames = int'(it.packet_frames);
      case (it.req_type)
         REQ_HEADER: begin
            // A new header always releases whatever the previous packet still had reserved.
            reserved_cnt = 0;
            packet_open = 1'b0;
            if (buf_mode == MODE_DROPPING) begin
               if (stored_cnt <= level) buf_mode = MODE_PROCESSING;
            end else if (stored_cnt + frames <= DEPTH_FRAMES) begin
               r.ok = 1'b1;
               reserved_cnt = frames;
               packet_open = (frames != 0);
               if (buf_mode == MODE_PREFETCHING && stored_cnt + reserved_cnt >= level)
                  buf_mode = MODE_PROCESSING;
            end else begin
               buf_mode = MODE_DROPPING;
            end
         end
         REQ_FRAME: begin
            if (packet_open && reserved_cnt != 0) begin
               shadow_frames[wr_ptr] = {it.right_in, it.left_in};
               wr_ptr = (wr_ptr + 1) % DEPTH_FRAMES;
               stored_cnt++;
               reserved_cnt--;
               if (reserved_cnt == 0) packet_open = 1'b0;
               r.ok = 1'b1;
            end
         end
         REQ_READ: begin
            if (buf_mode != MODE_PREFETCHING) begin
               if (stored_cnt == 0) begin
                  buf_mode = MODE_PREFETCHING;
               end else begin
                  w = shadow_frames[rd_ptr];
                  rd_ptr = (rd_ptr + 1) % DEPTH_FRAMES;
                  stored_cnt--;
                  r.left_out  = w[SAMPLE_W-1:0];
                  r.right_out = w[WORD_W-1:SAMPLE_W];
                  r.ok = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.buffer_mode = buf_mode;
      r.occupancy   = 14'(stored_cnt + reserved_cnt);
      fifo_outcomes.push_back(r);
   endtask

   task automatic queue_req(input logic [1:0] kind, input int frames,
                            input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
      req_item_type it;
      it.req_type      = kind;
      it.packet_frames = FRAMES_W'(frames);
      it.left_in       = left;
      it.right_in      = right;
      req_backlog.push_back(it);
   endtask

   // Mostly packets (a header, up to 12 frames, reads mixed in); the rest is
   // read bursts, stray frames, no-op codes and headers of random length.
   task automatic gen_traffic(input int count);
      int n;
      int k;
      int pick;
      while (req_backlog.size() < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) n = $urandom_range(1, 12);
            else if (pick < 78) n = 0;
            else if (pick < 90) n = $urandom_range(1000, DEPTH_FRAMES);
            else n = $urandom_range(DEPTH_FRAMES + 1, 16383);
            queue_req(REQ_HEADER, n, 16'($urandom), 16'($urandom));
            k = (n > 12) ? $urandom_range(0, 12) : n;
            if (k != 0 && $urandom_range(0, 7) == 0) k = $urandom_range(0, k - 1);
            repeat (k) begin
               if ($urandom_range(0, 2) == 0)
                  queue_req(REQ_READ, $urandom_range(0, 16383), 16'($urandom), 16'($urandom));
               queue_req(REQ_FRAME, $urandom_range(0, 16383), 16'($urandom), 16'($urandom));
            end
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 8))
               queue_req(REQ_READ, $urandom_range(0, 16383), 16'($urandom), 16'($urandom));
         end else if (pick < 92) begin
            queue_req(REQ_FRAME, $urandom_range(0, 16383), 16'($urandom), 16'($urandom));
         end else if (pick < 96) begin
            queue_req(REQ_NOP, $urandom_range(0, 16383), 16'($urandom), 16'($urandom));
         end else begin
            queue_req(REQ_HEADER, $urandom_range(0, 16383), 16'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic wait_drained;
      while (req_backlog.size() != 0 || fifo_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_level(input logic [LEVEL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      level = int'(value);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken = req_backlog.pop_front();
            jitter_fifo_step(taken);
         end
         if (req_valid && req_stall) begin
            // A stalled item stays on the port unchanged.
         end else if (send_wait != 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_valid <= 1'b1;
            req_item  <= req_backlog[0];
            if ($urandom_range(0, 39) == 0) send_idling = !send_idling;
            send_wait = next_wait(send_idling);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor and receiver stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (fifo_outcomes.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_item);
               errors++;
            end else begin
               want = fifo_outcomes.pop_front();
               if (rsp_item !== want) begin
                  $display("%0t: mismatch, expected ok=%0b left=%h right=%h mode=%0d occ=%0d",
                           $time, want.ok, want.left_out, want.right_out, want.buffer_mode,
                           want.occupancy,
                           ", actual ok=%0b left=%h right=%h mode=%0d occ=%0d",
                           rsp_item.ok, rsp_item.left_out, rsp_item.right_out,
                           rsp_item.buffer_mode, rsp_item.occupancy);
                  errors++;
               end
            end
            rsp_taken++;
            if ($urandom_range(0, 39) == 0) rcv_idling = !rcv_idling;
            rcv_wait = next_wait(rcv_idling);
            // Long back-pressure so the request side fills up and stalls.
            if (rsp_taken == 300 || rsp_taken == 900) rcv_wait = 400;
         end else if (rcv_wait != 0) begin
            rcv_wait--;
         end
         rsp_stall <= (rcv_wait != 0);
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases, starting from the reset level.
      queue_req(REQ_READ, 0, 16'h1234, 16'h5678);       // idle read while prefetching
      queue_req(REQ_NOP, 16383, 16'hFFFF, 16'hFFFF);    // no-op code
      queue_req(REQ_FRAME, 3, 16'hAAAA, 16'h5555);      // frame without a packet
      queue_req(REQ_HEADER, 0, 16'h0000, 16'h0000);     // empty packet
      queue_req(REQ_HEADER, 16383, 16'hFFFF, 16'hFFFF); // too long, starts dropping
      queue_req(REQ_HEADER, 5, 16'h0, 16'h0);           // discarded, back to processing
      queue_req(REQ_FRAME, 0, 16'h1111, 16'h2222);      // no reservation after a drop
      queue_req(REQ_READ, 0, 16'h0, 16'h0);             // empty read, back to prefetching
      queue_req(REQ_HEADER, DEPTH_FRAMES, 16'h0, 16'h0); // exactly fills the buffer
      queue_req(REQ_FRAME, 0, 16'h0000, 16'hFFFF);
      queue_req(REQ_FRAME, 16383, 16'hFFFF, 16'h0000);
      queue_req(REQ_FRAME, 0, 16'($urandom), 16'($urandom));
      queue_req(REQ_HEADER, 2, 16'h0, 16'h0);           // cuts the unfinished packet short
      queue_req(REQ_FRAME, 0, 16'($urandom), 16'($urandom));
      queue_req(REQ_FRAME, 0, 16'($urandom), 16'($urandom));
      queue_req(REQ_FRAME, 0, 16'($urandom), 16'($urandom)); // beyond the packet
      queue_req(REQ_HEADER, DEPTH_FRAMES - 5, 16'h0, 16'h0);
      queue_req(REQ_HEADER, DEPTH_FRAMES - 4, 16'h0, 16'h0);
      repeat (6) queue_req(REQ_READ, 0, 16'h0, 16'h0);  // pop all five, then underrun
      queue_req(REQ_READ, 0, 16'h0, 16'h0);
      wait_drained;

      write_level(LEVEL_W'(16));
      gen_traffic(400);
      wait_drained;
      write_level('0);
      gen_traffic(250);
      wait_drained;
      write_level(LEVEL_W'(DEPTH_FRAMES));
      gen_traffic(150);
      wait_drained;
      write_level(LEVEL_W'($urandom_range(1, 63)));
      gen_traffic(250);
      wait_drained;
      write_level('1);
      gen_traffic(60);
      wait_drained;
      write_level(PREFETCH_RESET);
      gen_traffic(120);
      wait_drained;
      write_level(LEVEL_W'($urandom_range(1, 300)));
      gen_traffic(120);
      wait_drained;

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("FAIL");
      $finish;
   end

endmodule
